### sv/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge of clk while rst is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge of clk, reset cycles included
`define ASSERT_CLK_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/srr_pkg.sv
package srr_pkg;

  localparam int MAX_ORBITALS = 32;
  localparam int TBL_DIM      = MAX_ORBITALS + 1;
  localparam int TBL_DEPTH    = TBL_DIM * TBL_DIM;
  localparam int ADDR_W       = $clog2(TBL_DEPTH);

  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 1;
  localparam int WGT_W        = 30;
  localparam int STR_W        = 32;
  localparam int BITIDX_W     = $clog2(STR_W);
  localparam int IN_DATA_W    = 64;
  localparam int OUT_DATA_W   = 32;

  localparam logic [CFG_W-1:0] K_RESET = CFG_W'(8);
  localparam logic [CFG_W-1:0] N_RESET = CFG_W'(4);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ORBITALS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_ELECTRONS = 1'b1;

  typedef enum logic [3:0] {
    ST_BUILD_RD,
    ST_BUILD_WR,
    ST_IDLE,
    ST_CHECK,
    ST_RANK,
    ST_RANK_END,
    ST_UN_DIM,
    ST_UN_CHK,
    ST_UN_RD,
    ST_UN_CMP,
    ST_DONE
  } srr_state_t;

  typedef struct packed {
    logic build_rd;
    logic build_wr;
    logic load;
    logic check;
    logic rank_step;
    logic dim_rd;
    logic dim_chk;
    logic un_rd;
    logic un_cmp;
    logic out_load;
  } srr_cmd_t;

  typedef struct packed {
    logic build_last;
    logic is_unrank;
    logic pre_bad;
    logic k_zero;
    logic rank_last;
    logic dim_fail;
    logic n_zero;
    logic un_last;
    logic out_free;
  } srr_stat_t;

  // row-major table address of entry (p, m)
  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [CFG_W-1:0] p,
                                                 input logic [CFG_W-1:0] m);
    return ADDR_W'(p) * ADDR_W'(TBL_DIM) + ADDR_W'(m);
  endfunction

  // entry (p, m) is nonzero for the current k and n only inside this band
  function automatic logic in_band(input logic [CFG_W-1:0] p,
                                   input logic [CFG_W-1:0] m,
                                   input logic [CFG_W-1:0] k,
                                   input logic [CFG_W-1:0] n);
    logic [CFG_W:0] lhs;
    logic [CFG_W:0] rhs;
    lhs = {1'b0, p} + {1'b0, n};
    rhs = {1'b0, k} + {1'b0, m};
    return (n <= k) && (m <= n) && (m <= p) && (lhs <= rhs);
  endfunction

endpackage

### sv/subset_rank_unrank.sv
// subset rank / unrank: maps K-bit strings with exactly N set bits to addresses
// 0 .. C(K,N)-1 in reverse-lexical order (combinatorial number system) and back.
// tuser of a request picks the command: 0 ranks tdata[31:0], 1 unranks
// tdata[61:32]. the result comes back on m_axis with tuser set and tdata zero
// when the string has the wrong popcount or a bit at or above K, or when the
// address is not below C(K,N). the user writes K (num_orbitals, index 0, values
// above 32 are taken as 32) and N (num_electrons, index 1) on the cfg port only
// while the block is idle; the block itself does not enforce this. after reset
// and after every register write the binomial weight table (561 entries, the
// lower triangle of a 33 x 33 dual-read-port ram) is rebuilt one entry at a
// time, and no request is taken meanwhile. one request is in work at a time; a
// ram read comes ahead of each compare and add. a rank walks bit positions 0 to
// K-1, reading the weight of each set bit and adding it to the sum, read and add
// pipelined; an unrank walks the positions from the top until all N bits are
// placed or the bottom is reached (read, then compare and subtract). N above K,
// or a set bit at or above K, is caught at once, as is a rank with K zero; an
// address too large is caught after the read of C(K,N). a wrong popcount only
// shows at the end of the full rank walk. a finished result waits until the
// output register is free; the next request may be accepted while a result
// still waits in the output register.
`include "assert_macros.svh"

module subset_rank_unrank (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_we,
  input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srr_pkg::CFG_W-1:0]         cfg_data,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [srr_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // bit_string[31:0], rank_in[61:32]
  input  logic                              s_axis_tuser,  // cmd
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [srr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // result_word[31:0]
  output logic                              m_axis_tuser   // bad_input
);

  srr_pkg::srr_cmd_t  cmd;
  srr_pkg::srr_stat_t stat;

  // sequencer: table build, rank walk, unrank walk, result hand-off
  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // weight ram, walk registers, output register
  srr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

  // the sequencer drives at most one datapath command per cycle
  `ASSERT_CLK(a_one_cmd, $onehot0(cmd), "more than one datapath command at once")

  // a result is only loaded when the output register can take it
  `ASSERT_CLK(a_out_free, cmd.out_load |-> stat.out_free, "result loaded over a waiting result")

  // after a request is taken the block works on it before taking another
  `ASSERT_CLK(a_one_item, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready,
              "request taken while one is in work")

  // a flagged result carries a zero word
  `ASSERT_CLK(a_bad_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0),
              "flagged result with nonzero word")

endmodule

### sv/srr_ctrl.sv
module srr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  output logic                in_ready,
  output srr_pkg::srr_cmd_t   cmd,
  input  srr_pkg::srr_stat_t  stat
);

  srr_pkg::srr_state_t state;
  srr_pkg::srr_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srr_pkg::ST_BUILD_RD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      srr_pkg::ST_BUILD_RD: begin
        cmd.build_rd = 1'b1;
        state_next   = srr_pkg::ST_BUILD_WR;
      end
      srr_pkg::ST_BUILD_WR: begin
        cmd.build_wr = 1'b1;
        state_next   = stat.build_last ? srr_pkg::ST_IDLE : srr_pkg::ST_BUILD_RD;
      end
      srr_pkg::ST_IDLE: begin
        in_ready = !cfg_we;
        if (in_valid && !cfg_we) begin
          cmd.load   = 1'b1;
          state_next = srr_pkg::ST_CHECK;
        end
      end
      srr_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        if (stat.pre_bad) begin
          state_next = srr_pkg::ST_DONE;
        end else if (stat.is_unrank) begin
          state_next = srr_pkg::ST_UN_DIM;
        end else if (stat.k_zero) begin
          state_next = srr_pkg::ST_DONE;
        end else begin
          state_next = srr_pkg::ST_RANK;
        end
      end
      srr_pkg::ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (stat.rank_last) begin
          state_next = srr_pkg::ST_RANK_END;
        end
      end
      srr_pkg::ST_RANK_END: begin
        state_next = srr_pkg::ST_DONE;
      end
      srr_pkg::ST_UN_DIM: begin
        cmd.dim_rd = 1'b1;
        state_next = srr_pkg::ST_UN_CHK;
      end
      srr_pkg::ST_UN_CHK: begin
        cmd.dim_chk = 1'b1;
        state_next  = (stat.dim_fail || stat.n_zero) ? srr_pkg::ST_DONE : srr_pkg::ST_UN_RD;
      end
      srr_pkg::ST_UN_RD: begin
        cmd.un_rd  = 1'b1;
        state_next = srr_pkg::ST_UN_CMP;
      end
      srr_pkg::ST_UN_CMP: begin
        cmd.un_cmp = 1'b1;
        state_next = stat.un_last ? srr_pkg::ST_DONE : srr_pkg::ST_UN_RD;
      end
      srr_pkg::ST_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = srr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = srr_pkg::ST_BUILD_RD;
      end
    endcase
    // a register write restarts the table build
    if (cfg_we) begin
      state_next = srr_pkg::ST_BUILD_RD;
    end
  end

endmodule

### sv/srr_datapath.sv
module srr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srr_pkg::CFG_W-1:0]         cfg_data,
  input  logic [srr_pkg::IN_DATA_W-1:0]     in_data,
  input  logic                              in_user,
  input  srr_pkg::srr_cmd_t                 cmd,
  output srr_pkg::srr_stat_t                stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [srr_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_user
);

  localparam int AW = srr_pkg::ADDR_W;
  localparam int CW = srr_pkg::CFG_W;
  localparam int WW = srr_pkg::WGT_W;
  localparam int SW = srr_pkg::STR_W;

  logic [WW-1:0] mem [0:srr_pkg::TBL_DEPTH-1];

  // configuration
  logic [CW-1:0] k;
  logic [CW-1:0] n;

  // build counters
  logic [CW-1:0] bp;
  logic [CW-1:0] bm;
  logic [CW-1:0] bp_m1;
  logic [CW-1:0] bm_m1;
  logic          build_sum;

  // read ports
  logic [CW-1:0] pa;
  logic [CW-1:0] ma;
  logic          rd_en;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [AW-1:0] wr_addr;
  logic [WW-1:0] wr_data;
  logic [WW-1:0] rd_a;
  logic [WW-1:0] rd_b;
  logic          ok_a;
  logic [WW-1:0] w_a;

  // item state
  logic          is_unrank;
  logic [SW-1:0] sbits;
  logic [WW-1:0] addr;
  logic [CW-1:0] p;
  logic [CW-1:0] m;
  logic [CW-1:0] cnt;
  logic [WW-1:0] acc;
  logic [SW-1:0] ubits;
  logic          bad;
  logic          pend;

  logic [CW-1:0] p_m1;
  logic [CW-1:0] cnt_p1;
  logic [SW:0]   low_mask_w;
  logic [SW-1:0] low_mask;
  logic          pre_bad;
  logic          take;
  logic          final_bad;
  logic [SW-1:0] res;

  assign bp_m1     = bp - 1'b1;
  assign bm_m1     = bm - 1'b1;
  assign build_sum = (bm != '0) && (bm != bp);
  assign p_m1      = p - 1'b1;
  assign cnt_p1    = cnt + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= srr_pkg::K_RESET;
      n <= srr_pkg::N_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srr_pkg::REG_NUM_ORBITALS: begin
          k <= (cfg_data > CW'(srr_pkg::MAX_ORBITALS)) ? CW'(srr_pkg::MAX_ORBITALS) : cfg_data;
        end
        srr_pkg::REG_NUM_ELECTRONS: begin
          n <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // pascal triangle, row by row
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      bp <= '0;
      bm <= '0;
    end else if (cmd.build_wr) begin
      if (bm == bp) begin
        bm <= '0;
        bp <= bp + 1'b1;
      end else begin
        bm <= bm + 1'b1;
      end
    end
  end

  always_comb begin
    pa    = '0;
    ma    = '0;
    rd_en = 1'b0;
    if (cmd.build_rd) begin
      pa    = bp_m1;
      ma    = bm;
      rd_en = build_sum;
    end else if (cmd.rank_step) begin
      pa    = p;
      ma    = cnt_p1;
      rd_en = sbits[0];
    end else if (cmd.dim_rd) begin
      pa    = k;
      ma    = n;
      rd_en = 1'b1;
    end else if (cmd.un_rd) begin
      pa    = p_m1;
      ma    = m;
      rd_en = 1'b1;
    end
  end

  assign addr_a  = srr_pkg::tbl_addr(pa, ma);
  assign addr_b  = srr_pkg::tbl_addr(bp_m1, bm_m1);
  assign wr_addr = srr_pkg::tbl_addr(bp, bm);
  assign wr_data = build_sum ? (rd_a + rd_b) : WW'(1);

  always_ff @(posedge clk) begin
    if (cmd.build_wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
      ok_a <= srr_pkg::in_band(pa, ma, k, n);
    end
  end

  // entries outside the band read as zero
  assign w_a  = ok_a ? rd_a : '0;
  assign take = (w_a <= addr);

  assign low_mask_w = ({{SW{1'b0}}, 1'b1} << k) - 1'b1;
  assign low_mask   = low_mask_w[SW-1:0];
  assign pre_bad    = (n > k) || (!is_unrank && ((sbits & ~low_mask) != '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= cmd.rank_step && sbits[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_unrank <= in_user;
      sbits     <= in_data[SW-1:0];
      addr      <= in_data[SW+WW-1:SW];
      p         <= in_user ? k : '0;
      m         <= n;
      cnt       <= '0;
      acc       <= '0;
      ubits     <= '0;
      bad       <= 1'b0;
    end else begin
      // failed pre-check, or an address at or above the dimension
      if ((cmd.check && pre_bad) || (cmd.dim_chk && take)) begin
        bad <= 1'b1;
      end
      if (cmd.rank_step) begin
        sbits <= sbits >> 1;
        p     <= p + 1'b1;
        if (sbits[0]) begin
          cnt <= cnt_p1;
        end
      end
      if (pend) begin
        acc <= acc + w_a;
      end
      if (cmd.un_cmp) begin
        p <= p_m1;
        if (take) begin
          addr                       <= addr - w_a;
          ubits[p_m1[srr_pkg::BITIDX_W-1:0]] <= 1'b1;
          m                          <= m - 1'b1;
        end
      end
    end
  end

  assign final_bad = bad || (!is_unrank && (cnt != n));
  assign res       = is_unrank ? ubits : {{(SW-WW){1'b0}}, acc};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= final_bad ? '0 : srr_pkg::OUT_DATA_W'(res);
      out_user <= final_bad;
    end
  end

  always_comb begin
    stat.build_last = (bp == CW'(srr_pkg::MAX_ORBITALS)) && (bm == CW'(srr_pkg::MAX_ORBITALS));
    stat.is_unrank  = is_unrank;
    stat.pre_bad    = pre_bad;
    stat.k_zero     = (k == '0);
    stat.rank_last  = (({1'b0, p} + 1'b1) == {1'b0, k});
    stat.dim_fail   = take;
    stat.n_zero     = (n == '0);
    stat.un_last    = (take && (m == CW'(1))) || (p == CW'(1));
    stat.out_free   = !out_valid || out_ready;
  end

endmodule

### sim/tb_subset_rank_unrank.sv
`timescale 1ns / 1ps

module tb_subset_rank_unrank;

  // command carried in tuser of a request
  localparam logic CMD_RANK   = 1'b0;
  localparam logic CMD_UNRANK = 1'b1;

  // cycles with no traffic at all before the run is abandoned
  localparam int WATCHDOG_LIMIT = 20000;
  // quiet cycles after the last result, well above the slowest unrank
  localparam int DRAIN_CYCLES   = 100;
  localparam int MAX_REPORTS    = 100;

  typedef struct packed {
    logic        cmd;
    logic [29:0] addr;
    logic [31:0] bits;
  } request_t;

  typedef struct packed {
    logic [31:0] word;
    logic        bad;
  } result_t;

  logic                           clk           = 1'b0;
  logic                           rst           = 1'b1;
  logic                           cfg_we        = 1'b0;
  logic [srr_pkg::CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [srr_pkg::CFG_W-1:0]      cfg_data      = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [srr_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;  // bit_string[31:0], rank_in[61:32]
  logic                           s_axis_tuser  = 1'b0; // cmd
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [srr_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // result_word[31:0]
  logic                           m_axis_tuser;        // bad_input

  subset_rank_unrank uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow of the block: register copies and its own binomial weight table
  // ---------------------------------------------------------------------------
  int unsigned       orbitals_reg  = 8;
  int unsigned       electrons_reg = 4;
  longint unsigned   binom_weight [srr_pkg::TBL_DIM][srr_pkg::TBL_DIM];

  request_t          pending_requests [$];
  result_t           expected_results [$];

  int                mismatch_count = 0;
  int                results_checked = 0;
  int                flagged_count  = 0;
  int                rank_count     = 0;
  int                unrank_count   = 0;
  int                setting_count  = 1;

  // K above the maximum is taken as the maximum
  function automatic int active_orbitals();
    return (orbitals_reg > srr_pkg::MAX_ORBITALS) ? srr_pkg::MAX_ORBITALS : int'(orbitals_reg);
  endfunction

  // pascal band: ones down column 0, each entry the sum of the two above it
  function automatic void rebuild_weights();
    int k;
    int n;
    k = active_orbitals();
    n = int'(electrons_reg);
    for (int p = 0; p < srr_pkg::TBL_DIM; p++)
      for (int m = 0; m < srr_pkg::TBL_DIM; m++)
        binom_weight[p][m] = 0;
    if (n > k)
      return;
    for (int p = 0; p <= k - n; p++)
      binom_weight[p][0] = 1;
    for (int m = 1; m <= n; m++)
      for (int p = m; p <= k - n + m; p++)
        binom_weight[p][m] = binom_weight[p-1][m] + binom_weight[p-1][m-1];
  endfunction

  // address of a string, or the string at an address, under the current K and N
  function automatic result_t predict_subset_result(input request_t req);
    result_t         res;
    int              k;
    int              n;
    int              m;
    int              ones;
    longint unsigned acc;
    longint unsigned rest;
    longint unsigned w;
    k       = active_orbitals();
    n       = int'(electrons_reg);
    res.bad = 1'b0;
    acc     = 0;
    if (n > k) begin
      // empty table: nothing is in range
      res.bad = 1'b1;
    end else if (req.cmd == CMD_RANK) begin
      if ((64'(req.bits) >> k) != 0) begin
        res.bad = 1'b1;
      end else begin
        ones = 0;
        for (int p = 0; p < srr_pkg::STR_W; p++) begin
          if (req.bits[p]) begin
            ones++;
            acc += binom_weight[p][ones];
          end
        end
        if (ones != n)
          res.bad = 1'b1;
      end
    end else begin
      rest = 64'(req.addr);
      if (rest >= binom_weight[k][n]) begin
        res.bad = 1'b1;
      end else if (n != 0) begin
        // walk down from the top orbital, placing a bit wherever the weight fits
        m = n;
        for (int p = k; p > 0 && m > 0; p--) begin
          w = binom_weight[p-1][m];
          if (w <= rest) begin
            rest -= w;
            acc  |= 64'd1 << (p - 1);
            m--;
          end
        end
      end
    end
    res.word = res.bad ? '0 : acc[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(input logic cmd, input logic [31:0] bits,
                               input logic [29:0] addr);
    request_t req;
    req.cmd  = cmd;
    req.bits = bits;
    req.addr = addr;
    pending_requests.push_back(req);
  endtask

  // n distinct set bits among the k lowest; starts from all ones when n is large
  function automatic logic [31:0] random_subset(input int k, input int n);
    logic [31:0] s;
    logic        fill;
    int          left;
    int          p;
    fill = (2 * n > k);
    s    = fill ? 32'((64'd1 << k) - 1) : '0;
    left = fill ? k - n : n;
    while (left > 0) begin
      p = $urandom_range(k - 1, 0);
      if (s[p] == fill) begin
        s[p] = ~fill;
        left--;
      end
    end
    return s;
  endfunction

  // mostly well-formed strings and in-range addresses, the rest broken or noise
  task automatic queue_random_requests(input int count);
    request_t        req;
    int              k;
    int              n;
    int              sel;
    int              flip;
    longint unsigned dim;
    longint unsigned draw;
    k   = active_orbitals();
    n   = int'(electrons_reg);
    dim = (n <= k) ? binom_weight[k][n] : 0;
    for (int i = 0; i < count; i++) begin
      req  = '0;
      sel  = $urandom_range(99, 0);
      draw = $urandom;
      if (sel < 40) begin
        req.cmd  = CMD_RANK;
        req.bits = random_subset(k, (n < k) ? n : k);
      end else if (sel < 80) begin
        req.cmd  = CMD_UNRANK;
        req.addr = (dim > 0) ? 30'(draw % dim) : '0;
      end else if (sel < 86) begin
        // a valid string with one bit flipped: wrong popcount or a bit beyond K
        req.cmd        = CMD_RANK;
        req.bits       = random_subset(k, (n < k) ? n : k);
        flip           = $urandom_range(31, 0);
        req.bits[flip] = ~req.bits[flip];
      end else if (sel < 90) begin
        req.cmd  = CMD_RANK;
        req.bits = $urandom;
      end else if (sel < 95) begin
        req.cmd  = CMD_UNRANK;
        req.addr = 30'(draw);
      end else begin
        // just below, at and just above the dimension
        req.cmd = CMD_UNRANK;
        draw    = dim + $urandom_range(2, 0);
        if (draw > 0)
          draw--;
        req.addr = 30'(draw);
      end
      pending_requests.push_back(req);
    end
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // one write, then wait out the table rebuild that it starts
  task automatic write_register(input logic [srr_pkg::CFG_IDX_W-1:0] idx,
                                input int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[srr_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == srr_pkg::REG_NUM_ORBITALS)
      orbitals_reg = value & 6'h3F;
    else
      electrons_reg = value & 6'h3F;
    rebuild_weights();
    while (s_axis_tready)
      @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
  endtask

  task automatic configure(input int unsigned k, input int unsigned n);
    wait_drained();
    write_register(srr_pkg::REG_NUM_ORBITALS, k);
    write_register(srr_pkg::REG_NUM_ELECTRONS, n);
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  int       burst_left = 1;
  int       gap_left   = 0;
  request_t accepted_req;
  request_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        // request taken: its result is fixed by the settings in force now
        accepted_req.cmd  = s_axis_tuser;
        accepted_req.bits = s_axis_tdata[31:0];
        accepted_req.addr = s_axis_tdata[61:32];
        expected_results.push_back(predict_subset_result(accepted_req));
        if (s_axis_tuser == CMD_RANK)
          rank_count++;
        else
          unrank_count++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(40, 1);
          case ($urandom_range(3, 0))
            0:       gap_left = 0;
            1:       gap_left = $urandom_range(90, 30);
            default: gap_left = $urandom_range(12, 1);
          endcase
        end
      end
      // a held request stays put until taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          next_req      = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, next_req.addr, next_req.bits};
          s_axis_tuser  <= next_req.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: stretches of full readiness, random stalls and heavy stalls
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(2, 0);
        stall_left = $urandom_range(150, 20);
      end
      stall_left--;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= $urandom_range(1, 0);
        default: m_axis_tready <= ($urandom_range(7, 0) == 0);
      endcase
    end
  end

  // result checker: oldest expectation first, field by field
  result_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (m_axis_tuser)
        flagged_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with no request waiting: word %08h bad %0b",
                   $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata !== want.word) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: result_word expected %08h actual %08h",
                     $time, want.word, m_axis_tdata);
        end
        if (m_axis_tuser !== want.bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: bad_input expected %0b actual %0b",
                     $time, want.bad, m_axis_tuser);
        end
      end
    end
  end

  // watchdog: any handshake or register write counts as progress
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no traffic for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k_pick;
    int unsigned n_pick;

    rebuild_weights();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings K = 8, N = 4: 70 strings
    queue_request(CMD_RANK,   32'h0000_000F, '0);           // lowest string, address 0
    queue_request(CMD_RANK,   32'h0000_00F0, '0);           // highest string, address 69
    queue_request(CMD_RANK,   32'h0000_0055, '0);
    queue_request(CMD_RANK,   32'h0000_00AA, '0);
    queue_request(CMD_RANK,   32'h0000_0007, '0);           // popcount too low
    queue_request(CMD_RANK,   32'h0000_001F, '0);           // popcount too high
    queue_request(CMD_RANK,   32'h0000_0000, '0);
    queue_request(CMD_RANK,   32'h0000_0107, '0);           // bit at K
    queue_request(CMD_RANK,   32'h8000_0007, '0);           // top bit with three inside
    queue_request(CMD_RANK,   32'hFFFF_FFFF, 30'h3FFF_FFFF);
    queue_request(CMD_UNRANK, 32'hFFFF_FFFF, 30'd0);
    queue_request(CMD_UNRANK, '0, 30'd69);
    queue_request(CMD_UNRANK, '0, 30'd35);
    queue_request(CMD_UNRANK, '0, 30'd70);                  // equal to the dimension, one past the last address
    queue_request(CMD_UNRANK, '0, 30'h3FFF_FFFF);
    queue_request(CMD_UNRANK, '0, 30'h2000_0000);
    queue_request(CMD_UNRANK, '0, 30'h1555_5555);
    queue_request(CMD_RANK,   32'h5555_5555, '0);
    queue_request(CMD_RANK,   32'h0000_00C3, '0);
    queue_request(CMD_UNRANK, '0, 30'd1);

    // extremes: largest dimension, saturated K, empty strings, N above K
    configure(32, 16);
    queue_random_requests(300);
    configure(63, 5);
    queue_random_requests(100);
    configure(0, 0);
    queue_random_requests(30);
    configure(5, 7);
    queue_random_requests(40);
    configure(1, 1);
    queue_random_requests(40);
    configure(32, 32);
    queue_random_requests(60);
    configure(32, 0);
    queue_random_requests(60);
    configure(12, 63);
    queue_random_requests(20);

    // random legal settings
    for (int i = 0; i < 8; i++) begin
      k_pick = $urandom_range(32, 1);
      n_pick = $urandom_range(k_pick, 0);
      configure(k_pick, n_pick);
      queue_random_requests(110);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d rank and %0d unrank requests over %0d register settings",
             rank_count, unrank_count, setting_count);
    $display("%0d results checked, %0d flagged out of range, %0d mismatches",
             results_checked, flagged_count, mismatch_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
